### rtl/c2pa_pkg.sv
// shared types, widths and constants for the cartesian to polar angle converter
package c2pa_pkg;

  localparam int CORDIC_STEPS = 18;
  localparam int SQRT_STEPS   = 17;
  localparam int ITER_STAGES  = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;

  localparam int XW = 45;
  localparam int ZW = 34;
  localparam int SW = 35;

  localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic [29:0]          DEG_MUL     = 30'd961263669;

  localparam logic signed [ZW-1:0] ATAN_Q30 [32] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128,
    34'sd64,        34'sd32,        34'sd16,        34'sd8,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

  typedef enum logic [1:0] {
    REG_CENTER_X     = 2'd0,
    REG_CENTER_Y     = 2'd1,
    REG_ANGLE_FORMAT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FMT_DEG_SIGNED = 2'd0,
    FMT_DEG_POS    = 2'd1,
    FMT_RAD_SIGNED = 2'd2,
    FMT_RAD_POS    = 2'd3
  } angle_format_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
  } hit_t;

  typedef struct packed {
    logic [16:0]        radius;
    logic signed [19:0] angle;
  } polar_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [SW-1:0]        n;
    logic [SW-1:0]        r;
    logic                 dx_neg;
    logic                 dy_pos;
    logic                 dy_neg;
  } iter_t;

endpackage

### rtl/cartesian_to_polar_angle_format_top.sv
// cartesian to polar converter: centre offset, rounded radius and formatted angle
// throughput: one beat per cycle while the receiver does not stall; the pipeline is
// 24 register stages, set by the 18 cordic micro-rotations running alongside the
// 17 square-root digit steps
// reset: synchronous, clears all valid bits; centre 0, angle format signed radians
module cartesian_to_polar_angle_format_top (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 hit_valid,
  output logic                 hit_stall,
  input  c2pa_pkg::hit_t       hit,
  output logic                 polar_valid,
  input  logic                 polar_stall,
  output c2pa_pkg::polar_t     polar
);

  localparam int N  = c2pa_pkg::ITER_STAGES;
  localparam int XW = c2pa_pkg::XW;
  localparam int ZW = c2pa_pkg::ZW;
  localparam int SW = c2pa_pkg::SW;

  logic signed [15:0]        center_x;
  logic signed [15:0]        center_y;
  c2pa_pkg::angle_format_t   angle_format;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      angle_format <= c2pa_pkg::FMT_RAD_SIGNED;
    end else if (cfg_write) begin
      case (cfg_index)
        c2pa_pkg::REG_CENTER_X:     center_x <= cfg_data;
        c2pa_pkg::REG_CENTER_Y:     center_y <= cfg_data;
        c2pa_pkg::REG_ANGLE_FORMAT: angle_format <= c2pa_pkg::angle_format_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  logic en;
  assign en        = !polar_valid || !polar_stall;
  assign hit_stall = !en;

  // centre offset
  logic               s0_valid;
  logic signed [16:0] s0_dx;
  logic signed [16:0] s0_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= hit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx <= {hit.pos_x[15], hit.pos_x} - {center_x[15], center_x};
      s0_dy <= {hit.pos_y[15], hit.pos_y} - {center_y[15], center_y};
    end
  end

  // squares
  logic [15:0] s0_ax;
  logic [15:0] s0_ay;
  assign s0_ax = s0_dx[16] ? 16'(-s0_dx) : s0_dx[15:0];
  assign s0_ay = s0_dy[16] ? 16'(-s0_dy) : s0_dy[15:0];

  logic               s1_valid;
  logic [31:0]        s1_ax2;
  logic [31:0]        s1_ay2;
  logic signed [16:0] s1_dx;
  logic signed [16:0] s1_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ax2 <= s0_ax * s0_ax;
      s1_ay2 <= s0_ay * s0_ay;
      s1_dx  <= s0_dx;
      s1_dy  <= s0_dy;
    end
  end

  // sum of squares and quadrant pre-rotation
  c2pa_pkg::iter_t      pre;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;

  assign x0 = {{4{s1_dx[16]}}, s1_dx, 24'b0};
  assign y0 = {{4{s1_dy[16]}}, s1_dy, 24'b0};

  always_comb begin
    pre.x      = x0;
    pre.y      = y0;
    pre.z      = '0;
    pre.n      = SW'(s1_ax2) + SW'(s1_ay2);
    pre.r      = '0;
    pre.dx_neg = s1_dx[16];
    pre.dy_pos = !s1_dy[16] && (s1_dy != '0);
    pre.dy_neg = s1_dy[16];
    if (s1_dx[16]) begin
      if (!s1_dy[16]) begin
        pre.x = y0;
        pre.y = -x0;
        pre.z = c2pa_pkg::HALF_PI_Q30;
      end else begin
        pre.x = -y0;
        pre.y = x0;
        pre.z = -c2pa_pkg::HALF_PI_Q30;
      end
    end
  end

  logic            s2_valid;
  c2pa_pkg::iter_t s2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= pre;
    end
  end

  // cordic micro-rotations and square-root digits, at most one of each per stage
  logic            it_valid [N];
  c2pa_pkg::iter_t it_q     [N];

  for (genvar k = 0; k < N; k++) begin : g_iter
    c2pa_pkg::iter_t      cur;
    c2pa_pkg::iter_t      nxt;
    logic                 cur_valid;
    logic signed [XW-1:0] x_n;
    logic signed [XW-1:0] y_n;
    logic signed [ZW-1:0] z_n;
    logic [SW-1:0]        n_n;
    logic [SW-1:0]        r_n;

    if (k == 0) begin : g_first
      assign cur       = s2;
      assign cur_valid = s2_valid;
    end else begin : g_next
      assign cur       = it_q[k-1];
      assign cur_valid = it_valid[k-1];
    end

    if (k < c2pa_pkg::CORDIC_STEPS) begin : g_rot
      logic signed [XW-1:0] xc;
      logic signed [XW-1:0] yc;
      logic signed [ZW-1:0] zc;
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      logic                 ypos;
      assign xc   = cur.x;
      assign yc   = cur.y;
      assign zc   = cur.z;
      assign xs   = xc >>> k;
      assign ys   = yc >>> k;
      assign ypos = !yc[XW-1] && (yc != '0);
      assign x_n  = ypos ? xc + ys : xc - ys;
      assign y_n  = ypos ? yc - xs : yc + xs;
      assign z_n  = ypos ? zc + c2pa_pkg::ATAN_Q30[k] : zc - c2pa_pkg::ATAN_Q30[k];
    end else begin : g_rot_hold
      assign x_n = cur.x;
      assign y_n = cur.y;
      assign z_n = cur.z;
    end

    if (k < c2pa_pkg::SQRT_STEPS) begin : g_sqrt
      localparam int            SH      = 2 * (c2pa_pkg::SQRT_STEPS - 1 - k);
      localparam logic [SW-1:0] SQR_BIT = SW'(1) << SH;
      logic [SW-1:0] trial;
      assign trial = cur.r + SQR_BIT;
      assign n_n   = (cur.n >= trial) ? cur.n - trial : cur.n;
      assign r_n   = (cur.n >= trial) ? (cur.r >> 1) + SQR_BIT : cur.r >> 1;
    end else begin : g_sqrt_hold
      assign n_n = cur.n;
      assign r_n = cur.r;
    end

    always_comb begin
      nxt        = cur;
      nxt.x      = x_n;
      nxt.y      = y_n;
      nxt.z      = z_n;
      nxt.n      = n_n;
      nxt.r      = r_n;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        it_valid[k] <= 1'b0;
      end else if (en) begin
        it_valid[k] <= cur_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_q[k] <= nxt;
      end
    end
  end

  // angle guards, format offset and radius rounding
  c2pa_pkg::iter_t      last;
  logic signed [ZW-1:0] z_g;
  logic signed [ZW-1:0] phi;
  logic signed [ZW-1:0] phi_off;

  assign last = it_q[N-1];

  always_comb begin
    z_g = last.z;
    if (last.dy_pos && z_g < 0) begin
      z_g = '0;
    end
    if (last.dy_neg && z_g > 0) begin
      z_g = '0;
    end
    if (z_g > c2pa_pkg::PI_Q30) begin
      z_g = c2pa_pkg::PI_Q30;
    end
    if (z_g < -c2pa_pkg::PI_Q30) begin
      z_g = -c2pa_pkg::PI_Q30;
    end
    if (last.dy_pos || last.dy_neg) begin
      phi = z_g;
    end else if (last.dx_neg) begin
      phi = c2pa_pkg::PI_Q30;
    end else begin
      phi = '0;
    end
    phi_off = angle_format[0] ? phi + c2pa_pkg::PI_Q30 : phi;
  end

  logic                 s3_valid;
  logic signed [ZW-1:0] s3_phi;
  logic signed [ZW-1:0] s3_phi_raw;
  logic [16:0]          s3_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= it_valid[N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_phi     <= phi_off;
      s3_phi_raw <= phi;
      s3_radius  <= last.r[16:0] + 17'(last.n > last.r);
    end
  end

  // degree scaling as two partial products
  logic                 s4_valid;
  logic signed [47:0]   s4_hi;
  logic [46:0]          s4_lo;
  logic signed [19:0]   s4_rad;
  logic [16:0]          s4_radius;
  logic [ZW:0]          rad_sum;

  assign rad_sum = {s3_phi[ZW-1], s3_phi} + (ZW+1)'(1 << 13);

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (en) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_hi     <= $signed(s3_phi[ZW-1:17]) * $signed({1'b0, c2pa_pkg::DEG_MUL});
      s4_lo     <= s3_phi[16:0] * c2pa_pkg::DEG_MUL;
      s4_rad    <= rad_sum[33:14];
      s4_radius <= s3_radius;
    end
  end

  // final rounding and output register
  logic [65:0] deg_sum;

  assign deg_sum = {s4_hi[47], s4_hi, 17'b0} + {19'b0, s4_lo} + (66'd1 << 45);

  always_ff @(posedge clk) begin
    if (rst) begin
      polar_valid <= 1'b0;
    end else if (en) begin
      polar_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      polar.radius <= s4_radius;
      polar.angle  <= angle_format[1] ? s4_rad : deg_sum[65:46];
    end
  end

  a_sqrt_remainder: assert property (@(posedge clk) disable iff (rst)
    it_valid[N-1] |-> (it_q[N-1].r[SW-1:17] == '0) && (it_q[N-1].n <= (it_q[N-1].r << 1)))
    else $error("square root remainder out of range");

  a_phi_range: assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> (s3_phi_raw >= -c2pa_pkg::PI_Q30) && (s3_phi_raw <= c2pa_pkg::PI_Q30))
    else $error("guarded angle outside half turn");

  a_deg_range: assert property (@(posedge clk) disable iff (rst)
    polar_valid && (angle_format == c2pa_pkg::FMT_DEG_SIGNED)
      |-> ($signed(polar.angle) >= -20'sd46080) && ($signed(polar.angle) <= 20'sd46080))
    else $error("signed degree angle out of range");

  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    hit_stall |-> polar_valid && polar_stall)
    else $error("input stalled without a held output beat");

endmodule

### test/c2pa_polar_check.sv
`timescale 1ns / 1ps
// checker for the polar converter: watches both channels, predicts each result and compares
module c2pa_polar_check (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              hit_valid,
  input  logic              hit_stall,
  input  c2pa_pkg::hit_t    hit,
  input  logic              polar_valid,
  input  logic              polar_stall,
  input  c2pa_pkg::polar_t  polar,
  output int                waiting,
  output int                failures
);

  localparam longint PRESCALE  = 64'sd16777216;
  localparam longint DEG_SCALE = longint'(c2pa_pkg::DEG_MUL);
  localparam longint PI_RAD    = longint'(c2pa_pkg::PI_Q30);
  localparam longint HALF_PI   = longint'(c2pa_pkg::HALF_PI_Q30);

  longint                  centre_x = 0;
  longint                  centre_y = 0;
  c2pa_pkg::angle_format_t fmt = c2pa_pkg::FMT_RAD_SIGNED;
  c2pa_pkg::polar_t        expected_polar [$];

  function automatic longint rounded_shift(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    return (v + half) >>> s;
  endfunction

  function automatic longint unsigned round_root(longint unsigned s);
    longint unsigned r, probe, n;
    r = 0;
    probe = 64'd1 << 62;
    n = s;
    while (probe > n) probe = probe >> 2;
    while (probe != 0) begin
      if (n >= r + probe) begin
        n = n - (r + probe);
        r = (r >> 1) + probe;
      end else begin
        r = r >> 1;
      end
      probe = probe >> 2;
    end
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  // vectoring rotation, angle in 2^-30 rad, only for a nonzero dy
  function automatic longint cordic_phi(longint dx, longint dy);
    longint x, y, z, t, xs, ys;
    x = dx * PRESCALE;
    y = dy * PRESCALE;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < c2pa_pkg::CORDIC_STEPS && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + longint'(c2pa_pkg::ATAN_Q30[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(c2pa_pkg::ATAN_Q30[i]);
      end
    end
    if (dy > 0 && z < 0) z = 0;
    if (dy < 0 && z > 0) z = 0;
    if (z > PI_RAD) z = PI_RAD;
    if (z < -PI_RAD) z = -PI_RAD;
    return z;
  endfunction

  function automatic c2pa_pkg::polar_t convert_hit(c2pa_pkg::hit_t h);
    longint           dx, dy, phi, ang;
    longint unsigned  ax, ay;
    c2pa_pkg::polar_t p;
    dx = longint'(h.pos_x) - centre_x;
    dy = longint'(h.pos_y) - centre_y;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (dy != 0) phi = cordic_phi(dx, dy);
    else if (dx < 0) phi = PI_RAD;
    else phi = 0;
    case (fmt)
      c2pa_pkg::FMT_DEG_SIGNED: ang = rounded_shift(phi * DEG_SCALE, 46);
      c2pa_pkg::FMT_DEG_POS:    ang = rounded_shift((phi + PI_RAD) * DEG_SCALE, 46);
      c2pa_pkg::FMT_RAD_SIGNED: ang = rounded_shift(phi, 14);
      default:                  ang = rounded_shift(phi + PI_RAD, 14);
    endcase
    p.radius = 17'(round_root(ax * ax + ay * ay));
    p.angle  = 20'(ang);
    return p;
  endfunction

  always @(posedge clk) begin
    c2pa_pkg::polar_t want;
    if (rst) begin
      centre_x = 0;
      centre_y = 0;
      fmt = c2pa_pkg::FMT_RAD_SIGNED;
      expected_polar.delete();
      failures = 0;
    end else begin
      if (polar_valid && !polar_stall) begin
        if (expected_polar.size() == 0) begin
          $error("result beat with none pending: radius %0d angle %0d",
                 polar.radius, polar.angle);
          failures++;
        end else begin
          want = expected_polar.pop_front();
          if (polar.radius !== want.radius) begin
            $error("radius: expected %0d, got %0d", want.radius, polar.radius);
            failures++;
          end
          if (polar.angle !== want.angle) begin
            $error("angle: expected %0d, got %0d", want.angle, polar.angle);
            failures++;
          end
        end
      end
      if (hit_valid && !hit_stall) expected_polar.push_back(convert_hit(hit));
      if (cfg_write) begin
        case (cfg_index)
          c2pa_pkg::REG_CENTER_X:     centre_x = longint'($signed(cfg_data));
          c2pa_pkg::REG_CENTER_Y:     centre_y = longint'($signed(cfg_data));
          c2pa_pkg::REG_ANGLE_FORMAT: fmt = c2pa_pkg::angle_format_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
    end
    waiting = expected_polar.size();
  end

endmodule

### test/cartesian_to_polar_angle_format_top_test.sv
`timescale 1ns / 1ps
// testbench top for the polar converter: clock, reset, stimulus, receiver stalls and verdict
module cartesian_to_polar_angle_format_top_test;

  localparam int         HALF_PERIOD = 10;
  localparam int         PHASES      = 12;
  localparam int         PHASE_HITS  = 75;
  localparam int         LONG_HOLD   = 80;
  localparam int         LATENCY     = 24;
  localparam int         CYCLE_LIMIT = 200000;
  localparam logic [1:0] REG_SPARE   = 2'd3;

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic [1:0]        cfg_index;
  logic [15:0]       cfg_data;
  logic              hit_valid;
  logic              hit_stall;
  c2pa_pkg::hit_t    hit;
  logic              polar_valid;
  logic              polar_stall;
  c2pa_pkg::polar_t  polar;
  int                waiting;
  int                failures;
  int                hold_requests = 0;
  bit                quiet = 1'b0;
  int                cycle_count = 0;

  c2pa_pkg::hit_t corner_hits [16] = '{
    '{16'sd0, 16'sd0},           '{16'sd100, 16'sd0},
    '{-16'sd100, 16'sd0},        '{16'sh7fff, 16'sd0},
    '{16'sh8000, 16'sd0},        '{16'sd0, 16'sh7fff},
    '{16'sd0, 16'sh8000},        '{16'sh7fff, 16'sh7fff},
    '{16'sh8000, 16'sh8000},     '{16'sh8000, 16'sh7fff},
    '{16'sh7fff, 16'sh8000},     '{16'sh8000, 16'sd1},
    '{16'sh8000, -16'sd1},       '{16'sd1, -16'sd1},
    '{-16'sd1, 16'sd1},          '{16'sd5, -16'sd3}
  };

  always #(HALF_PERIOD) clk = ~clk;

  cartesian_to_polar_angle_format_top u_top (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .hit_valid, .hit_stall, .hit, .polar_valid, .polar_stall, .polar
  );

  c2pa_polar_check u_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .hit_valid, .hit_stall, .hit, .polar_valid, .polar_stall, .polar,
    .waiting, .failures
  );

  function automatic c2pa_pkg::hit_t random_hit(logic signed [15:0] cx,
                                                logic signed [15:0] cy);
    c2pa_pkg::hit_t h;
    int             pick;
    h = c2pa_pkg::hit_t'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      h.pos_x = cx;
      h.pos_y = cy;
    end else if (pick < 16) begin
      h.pos_y = cy;
    end else if (pick < 22) begin
      h.pos_x = cx;
    end else if (pick < 32) begin
      h.pos_x = cx + 16'($urandom_range(0, 6)) - 16'd3;
      h.pos_y = cy + 16'($urandom_range(0, 6)) - 16'd3;
    end else if (pick < 40) begin
      h.pos_x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      h.pos_y = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
    end
    return h;
  endfunction

  task automatic send_hit(c2pa_pkg::hit_t h);
    hit_valid <= 1'b1;
    hit <= h;
    do @(posedge clk); while (hit_stall);
    @(negedge clk);
  endtask

  task automatic idle_hit(int cycles);
    hit_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    hit_valid <= 1'b0;
    while (waiting != 0) @(negedge clk);
  endtask

  task automatic configure(logic signed [15:0] cx, logic signed [15:0] cy,
                           c2pa_pkg::angle_format_t f);
    cfg_write <= 1'b1;
    cfg_index <= c2pa_pkg::REG_CENTER_X;
    cfg_data <= cx;
    @(negedge clk);
    cfg_index <= c2pa_pkg::REG_CENTER_Y;
    cfg_data <= cy;
    @(negedge clk);
    cfg_index <= c2pa_pkg::REG_ANGLE_FORMAT;
    cfg_data <= {14'($urandom), f};
    @(negedge clk);
    cfg_index <= REG_SPARE;
    cfg_data <= 16'($urandom);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // receiver side: short stall bursts, calm stretches and the requested long holds
  initial begin
    int holds_done;
    int calm;
    holds_done = 0;
    polar_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        polar_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        polar_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 39) == 0) begin
        calm = $urandom_range(50, 200);
        while (calm > 0 && hold_requests == holds_done) begin
          @(negedge clk);
          calm--;
        end
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        polar_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        polar_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic signed [15:0]      cx, cy;
    c2pa_pkg::angle_format_t fmt;
    bit                      gaps_on;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = c2pa_pkg::REG_CENTER_X;
    cfg_data = '0;
    hit_valid = 1'b0;
    hit = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset settings: centre at origin, signed radians
    foreach (corner_hits[i]) send_hit(corner_hits[i]);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        0: begin cx = 16'sd0;     cy = 16'sd0;     end
        1: begin cx = 16'sh8000;  cy = 16'sh8000;  end
        2: begin cx = 16'sh7fff;  cy = 16'sh7fff;  end
        3: begin cx = 16'sh8000;  cy = 16'sh7fff;  end
        4: begin cx = 16'sh7fff;  cy = 16'sh8000;  end
        default: begin cx = 16'($urandom); cy = 16'($urandom); end
      endcase
      fmt = c2pa_pkg::angle_format_t'(phase % 4);
      configure(cx, cy, fmt);
      gaps_on = (phase % 3 != 1) && (phase != PHASES - 1);
      if (phase == PHASES - 1) quiet <= 1'b1;
      if (phase == 1 || phase == 7) hold_requests <= hold_requests + 1;
      for (int n = 0; n < PHASE_HITS; n++) begin
        if (gaps_on && $urandom_range(0, 4) == 0) idle_hit($urandom_range(1, 7));
        send_hit(random_hit(cx, cy));
      end
    end

    drain();
    repeat (2 * LATENCY) @(negedge clk);
    if (failures == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### files.f
rtl/c2pa_pkg.sv
rtl/cartesian_to_polar_angle_format_top.sv
test/c2pa_polar_check.sv
test/cartesian_to_polar_angle_format_top_test.sv
